// ===== rtl/cre_pkg.sv =====
// cre_pkg: types, constants and helpers shared by the character range expander
// no dependencies

package cre_pkg;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	localparam int RUN_IDX_W = 5;

	localparam logic [7:0] CH_DASH = 8'h2d;
	localparam logic [7:0] CH_LA   = 8'h61;
	localparam logic [7:0] CH_LZ   = 8'h7a;
	localparam logic [7:0] CH_UA   = 8'h41;
	localparam logic [7:0] CH_UZ   = 8'h5a;
	localparam logic [7:0] CH_D0   = 8'h30;
	localparam logic [7:0] CH_D9   = 8'h39;

	localparam logic [1:0] CLS_NONE  = 2'd0;
	localparam logic [1:0] CLS_LOWER = 2'd1;
	localparam logic [1:0] CLS_UPPER = 2'd2;
	localparam logic [1:0] CLS_DIGIT = 2'd3;

	localparam logic [1:0] PEND_NONE  = 2'd0;
	localparam logic [1:0] PEND_START = 2'd1;
	localparam logic [1:0] PEND_DASH  = 2'd2;

	typedef struct packed {
		logic [7:0] in_char;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       out_last;
	} out_item_t;

	// one decoded step: a literal list of up to three bytes or a run lit[0]..lit[1]
	typedef struct packed {
		logic            is_run;
		logic [2:0][7:0] lit;
		logic [1:0]      cnt;
		logic            last;
	} job_t;

	function automatic logic [1:0] char_class(input logic [7:0] c);
		logic [1:0] cls;
		cls = CLS_NONE;
		if (c >= CH_LA && c <= CH_LZ)
			cls = CLS_LOWER;
		else if (c >= CH_UA && c <= CH_UZ)
			cls = CLS_UPPER;
		else if (c >= CH_D0 && c <= CH_D9)
			cls = CLS_DIGIT;
		return cls;
	endfunction

endpackage

// ===== rtl/cre_front.sv =====
// cre_front: accepts input items, tracks held start and dash, decodes each step into a job
// depends on cre_pkg

module cre_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_stall,
	input  cre_pkg::in_item_t src_item,
	output logic              push,
	output cre_pkg::job_t     push_job,
	input  logic              q_full
);
	import cre_pkg::*;

	logic [1:0] pend_q;
	logic [7:0] start_q;
	logic [1:0] pend_d;
	logic [7:0] start_d;
	logic [7:0] c;
	logic       fresh_hold;
	logic       is_range;
	logic [1:0] cls_start;
	job_t       job;
	logic       accept;

	assign c          = src_item.in_char;
	assign cls_start  = char_class(start_q);
	assign fresh_hold = (char_class(c) != CLS_NONE);
	assign is_range   = (cls_start != CLS_NONE) && (char_class(c) == cls_start) &&
		({1'b0, c} > ({1'b0, start_q} + 9'd1));

	always_comb begin
		job     = '0;
		pend_d  = pend_q;
		start_d = start_q;
		case (pend_q)
			PEND_NONE: begin
				if (fresh_hold) begin
					start_d = c;
					pend_d  = PEND_START;
				end else begin
					job.lit[0] = c;
					job.cnt    = 2'd1;
				end
			end
			PEND_START: begin
				if (c == CH_DASH) begin
					pend_d = PEND_DASH;
				end else begin
					job.lit[0] = start_q;
					if (fresh_hold) begin
						start_d = c;
						job.cnt = 2'd1;
					end else begin
						job.lit[1] = c;
						job.cnt    = 2'd2;
						pend_d     = PEND_NONE;
					end
				end
			end
			PEND_DASH: begin
				if (is_range) begin
					job.is_run = 1'b1;
					job.lit[0] = start_q;
					job.lit[1] = c;
					pend_d     = PEND_NONE;
					start_d    = '0;
				end else begin
					job.lit[0] = start_q;
					job.lit[1] = CH_DASH;
					if (fresh_hold) begin
						start_d = c;
						pend_d  = PEND_START;
						job.cnt = 2'd2;
					end else begin
						job.lit[2] = c;
						job.cnt    = 2'd3;
						pend_d     = PEND_NONE;
					end
				end
			end
			default: begin
				pend_d = PEND_NONE;
			end
		endcase

		if (src_item.in_last) begin
			if (pend_d == PEND_START || pend_d == PEND_DASH) begin
				job.lit[job.cnt] = start_d;
				job.cnt          = job.cnt + 2'd1;
			end
			if (pend_d == PEND_DASH) begin
				job.lit[job.cnt] = CH_DASH;
				job.cnt          = job.cnt + 2'd1;
			end
			job.last = 1'b1;
			pend_d   = PEND_NONE;
			start_d  = '0;
		end
	end

	assign src_stall = q_full;
	assign accept    = src_valid && !q_full;
	assign push      = accept && (job.is_run || job.cnt != 2'd0);
	assign push_job  = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= PEND_NONE;
			start_q <= '0;
		end else if (accept) begin
			pend_q  <= pend_d;
			start_q <= start_d;
		end
	end

endmodule

// ===== rtl/cre_queue.sv =====
// cre_queue: short job queue between front and back
// depends on cre_pkg

module cre_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cre_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output cre_pkg::job_t pop_job
);
	import cre_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (cnt_q == QCNT_W'(QDEPTH));
	assign valid   = (cnt_q != '0);
	assign pop_job = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== rtl/cre_back.sv =====
// cre_back: executes queued jobs, one output byte per cycle while the output is not stalled, into the output register
// depends on cre_pkg

module cre_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  cre_pkg::job_t      q_job,
	output logic               pop,
	output logic               dst_valid,
	input  logic               dst_stall,
	output cre_pkg::out_item_t dst_item
);
	import cre_pkg::*;

	job_t                 cur_q;
	logic                 busy_q;
	logic [RUN_IDX_W-1:0] idx_q;
	logic                 out_valid_q;
	out_item_t            out_q;
	logic                 emit;
	logic [7:0]           byte_v;
	logic                 last_byte;
	logic                 done;

	always_comb begin
		if (cur_q.is_run) begin
			byte_v    = cur_q.lit[0] + {{(8 - RUN_IDX_W){1'b0}}, idx_q};
			last_byte = (byte_v == cur_q.lit[1]);
		end else begin
			byte_v    = cur_q.lit[idx_q[1:0]];
			last_byte = (idx_q[1:0] == cur_q.cnt - 2'd1);
		end
	end

	assign emit = busy_q && (!out_valid_q || !dst_stall);
	assign done = emit && last_byte;
	assign pop  = q_valid && (!busy_q || done);

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= q_job;
		if (emit) begin
			out_q.out_char <= byte_v;
			out_q.out_last <= last_byte && cur_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (done) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + 1'b1;
			end
			if (emit)
				out_valid_q <= 1'b1;
			else if (!dst_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign dst_valid = out_valid_q;
	assign dst_item  = out_q;

endmodule

// ===== rtl/char_range_expander.sv =====
// char_range_expander: top level of the shorthand character range expander
// depends on cre_pkg, cre_front, cre_queue, cre_back

// Expands shorthand ranges x-y in a byte stream into the full run x..y when both ends are
// lowercase letters, uppercase letters or digits of one kind and y exceeds x by more than one;
// all other bytes pass through literally, and held bytes are flushed on the item marked last.
// The front end takes one input item per cycle and hands a decoded job to a two-entry queue;
// an item that only gets held produces no job. The back end emits one output byte per cycle
// while the output is not stalled, so a job yields its bytes one at a time: one to three
// for literal text, y-x+1 (three to 26) for a range. The input stalls only while the queue
// is full behind a long run or a stalled output.

module char_range_expander (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  cre_pkg::in_item_t  src_item,
	output logic               dst_valid,
	input  logic               dst_stall,
	output cre_pkg::out_item_t dst_item
);
	import cre_pkg::*;

	logic push;
	job_t push_job;
	logic q_full;
	logic pop;
	logic q_valid;
	job_t q_job;

	cre_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.push      (push),
		.push_job  (push_job),
		.q_full    (q_full)
	);

	cre_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.valid    (q_valid),
		.pop_job  (q_job)
	);

	cre_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_job     (q_job),
		.pop       (pop),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_item  (dst_item)
	);

endmodule
